// ----- hw/rtl/ansi_escape_sequence_parser_assert.svh -----
// Assertion macros for the escape sequence parser.
`ifndef ANSI_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH
`define ANSI_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

// Antecedent implies consequent in the same cycle.
`define AESP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("aesp: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define AESP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("aesp: next-cycle check failed");

`else

`define AESP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AESP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- hw/rtl/aesp_pkg.sv -----
`default_nettype none

package aesp_pkg;

    typedef enum logic [3:0] {
        ST_GROUND,
        ST_ESC,
        ST_ESC_INT,
        ST_CSI_ENTRY,
        ST_CSI_PARAM,
        ST_CSI_INT,
        ST_CSI_IGNORE,
        ST_STRING,
        ST_STRING_ESC
    } parse_state_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_PRINT,
        ACT_EXEC,
        ACT_ESC_DISP,
        ACT_CSI_DISP,
        ACT_CLEAR,
        ACT_PRIVATE,
        ACT_DIGIT,
        ACT_SEP,
        ACT_INTER
    } act_t;

    localparam logic [1:0] EV_PRINT = 2'd0;
    localparam logic [1:0] EV_EXEC  = 2'd1;
    localparam logic [1:0] EV_ESC   = 2'd2;
    localparam logic [1:0] EV_CSI   = 2'd3;

    localparam logic [7:0] C_BEL      = 8'h07;
    localparam logic [7:0] C_CAN      = 8'h18;
    localparam logic [7:0] C_SUB      = 8'h1A;
    localparam logic [7:0] C_ESC      = 8'h1B;
    localparam logic [7:0] C_C0_END   = 8'h20;
    localparam logic [7:0] C_INTER_HI = 8'h2F;
    localparam logic [7:0] C_DIGIT_0  = 8'h30;
    localparam logic [7:0] C_DIGIT_9  = 8'h39;
    localparam logic [7:0] C_COLON    = 8'h3A;
    localparam logic [7:0] C_SEMI     = 8'h3B;
    localparam logic [7:0] C_PRIV_LO  = 8'h3C;
    localparam logic [7:0] C_PRIV_HI  = 8'h3F;
    localparam logic [7:0] C_FINAL_LO = 8'h40;
    localparam logic [7:0] C_FINAL_HI = 8'h7E;
    localparam logic [7:0] C_DCS      = 8'h50;
    localparam logic [7:0] C_SOS      = 8'h58;
    localparam logic [7:0] C_CSI_OPEN = 8'h5B;
    localparam logic [7:0] C_BSLASH   = 8'h5C;
    localparam logic [7:0] C_OSC      = 8'h5D;
    localparam logic [7:0] C_PM       = 8'h5E;
    localparam logic [7:0] C_APC      = 8'h5F;

    localparam logic [13:0] PVAL_MAX   = 14'd16383;
    localparam logic [14:0] PVAL_EMPTY = 15'h7FFF;

endpackage

`default_nettype wire

// ----- hw/rtl/aesp_byte_if.sv -----
`default_nettype none

interface aesp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/aesp_result_if.sv -----
`default_nettype none

interface aesp_result_if;
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic [7:0]        code_byte;
    logic [7:0]        private_marker;
    logic [5:0]        intermediate_byte;
    logic [5:0]        param_count;
    logic [4:0]        param_index;
    logic signed [14:0] param_value;
    logic              param_is_sub;
    logic              last_of_run;

    modport source (
        output valid, output event_kind, output code_byte, output private_marker,
        output intermediate_byte, output param_count, output param_index,
        output param_value, output param_is_sub, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input event_kind, input code_byte, input private_marker,
        input intermediate_byte, input param_count, input param_index,
        input param_value, input param_is_sub, input last_of_run,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/ansi_escape_sequence_parser.sv -----
// Channel   Dir  Interface        Word
// stream    in   aesp_byte_if     data_byte: one raw byte of terminal output
// results   out  aesp_result_if   one event, or one parameter of a CSI dispatch
//
// Cycles: one byte a cycle while the output register drains; a CSI final with
//   parameters holds the input while the parameter RAM is read out, one entry
//   a cycle while the output register drains.
// Reset: rst_n is asynchronous, active low; the parameter RAM needs no clearing
//   pass, as the fill count alone says which entries are live.
// Stalls: input waits during a parameter run or while the output word is held.
`default_nettype none

`include "ansi_escape_sequence_parser_assert.svh"

module ansi_escape_sequence_parser
    import aesp_pkg::*;
#(
    parameter int MAX_PARAMS = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    aesp_byte_if.sink      stream,
    aesp_result_if.source  results
);

    localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CNT_W = $clog2(MAX_PARAMS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARAMS);

    // ------------------------------------------------------------------
    // Parser state and collected sequence fields
    // ------------------------------------------------------------------
    parse_state_t            parse_reg, parse_next, eff_state;
    act_t                    act;
    logic [CNT_W-1:0]        total_reg, total_next;
    logic                    digits_reg, digits_next;
    logic                    sep_reg, sep_next;
    logic [MAX_PARAMS-1:0]   mask_reg, mask_next;
    logic [5:0]              inter_reg, inter_next;
    logic [7:0]              priv_reg, priv_next;
    // Forwarded copy of the value last written by a digit, so digits can follow back to back
    logic [13:0]             cur_reg, cur_next;

    // Parameter run sequencer
    logic                    run_busy_reg;
    logic [CNT_W-1:0]        rd_idx_reg;
    logic                    rd_pend_reg;
    logic [IDX_W-1:0]        rd_pidx_reg;
    logic                    rd_plast_reg;
    logic [7:0]              final_reg;

    // Output register
    logic                    out_valid_reg;
    logic [1:0]              out_kind_reg;
    logic [7:0]              out_code_reg;
    logic [7:0]              out_priv_reg;
    logic [5:0]              out_inter_reg;
    logic [5:0]              out_count_reg;
    logic [4:0]              out_index_reg;
    logic [14:0]             out_value_reg;
    logic                    out_sub_reg;
    logic                    out_last_reg;

    logic [7:0]              c;
    logic                    accept;
    logic                    pre_clear;
    logic                    is_c0, is_inter, is_final, is_digit, is_priv, is_sep, is_str;

    assign c      = stream.data_byte;
    assign accept = stream.valid && stream.ready;

    // ESC inside a string followed by anything but backslash acts as a fresh ESC.
    assign pre_clear = (parse_reg == ST_STRING_ESC) && (c != C_BSLASH);
    assign eff_state = pre_clear ? ST_ESC : parse_reg;

    assign is_c0    = c < C_C0_END;
    assign is_inter = c <= C_INTER_HI;
    assign is_final = (c >= C_FINAL_LO) && (c <= C_FINAL_HI);
    assign is_digit = (c >= C_DIGIT_0) && (c <= C_DIGIT_9);
    assign is_priv  = (c >= C_PRIV_LO) && (c <= C_PRIV_HI);
    assign is_sep   = (c == C_SEMI) || (c == C_COLON);
    assign is_str   = (c == C_OSC) || (c == C_DCS) || (c == C_SOS) ||
                      (c == C_PM) || (c == C_APC);

    // ------------------------------------------------------------------
    // Next parse state
    // ------------------------------------------------------------------
    always_comb
    begin
        parse_next = parse_reg;
        if (parse_reg == ST_STRING)
        begin
            if (c == C_ESC)
            begin
                parse_next = ST_STRING_ESC;
            end
            else if ((c == C_BEL) || (c == C_CAN) || (c == C_SUB))
            begin
                parse_next = ST_GROUND;
            end
        end
        else if ((parse_reg == ST_STRING_ESC) && !pre_clear)
        begin
            parse_next = ST_GROUND;
        end
        else if (is_c0)
        begin
            if (c == C_ESC)
            begin
                parse_next = ST_ESC;
            end
            else if ((c == C_CAN) || (c == C_SUB))
            begin
                parse_next = ST_GROUND;
            end
            else
            begin
                parse_next = eff_state;
            end
        end
        else
        begin
            case (eff_state)
                ST_GROUND:
                begin
                    parse_next = ST_GROUND;
                end
                ST_ESC:
                begin
                    if (c == C_CSI_OPEN)
                    begin
                        parse_next = ST_CSI_ENTRY;
                    end
                    else if (is_str)
                    begin
                        parse_next = ST_STRING;
                    end
                    else if (is_inter)
                    begin
                        parse_next = ST_ESC_INT;
                    end
                    else
                    begin
                        parse_next = ST_GROUND;
                    end
                end
                ST_ESC_INT:
                begin
                    parse_next = is_inter ? ST_ESC_INT : ST_GROUND;
                end
                ST_CSI_ENTRY, ST_CSI_PARAM:
                begin
                    if ((eff_state == ST_CSI_ENTRY) && is_priv)
                    begin
                        parse_next = ST_CSI_PARAM;
                    end
                    else if (is_digit || is_sep)
                    begin
                        parse_next = ST_CSI_PARAM;
                    end
                    else if (is_inter)
                    begin
                        parse_next = ST_CSI_INT;
                    end
                    else if (is_final)
                    begin
                        parse_next = ST_GROUND;
                    end
                    else
                    begin
                        parse_next = ST_CSI_IGNORE;
                    end
                end
                ST_CSI_INT:
                begin
                    if (is_inter)
                    begin
                        parse_next = ST_CSI_INT;
                    end
                    else if (is_final)
                    begin
                        parse_next = ST_GROUND;
                    end
                    else
                    begin
                        parse_next = ST_CSI_IGNORE;
                    end
                end
                ST_CSI_IGNORE:
                begin
                    parse_next = is_final ? ST_GROUND : ST_CSI_IGNORE;
                end
                default:
                begin
                    // Unknown encodings fall back to ground silently.
                    parse_next = ST_GROUND;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Action taken by this byte
    // ------------------------------------------------------------------
    always_comb
    begin
        act = ACT_NONE;
        if ((parse_reg == ST_STRING) || ((parse_reg == ST_STRING_ESC) && !pre_clear))
        begin
            act = ACT_NONE;
        end
        else if (is_c0)
        begin
            if (c == C_ESC)
            begin
                act = ACT_CLEAR;
            end
            else if ((c == C_CAN) || (c == C_SUB))
            begin
                act = ACT_NONE;
            end
            else
            begin
                act = ACT_EXEC;
            end
        end
        else
        begin
            case (eff_state)
                ST_GROUND:
                begin
                    act = ACT_PRINT;
                end
                ST_ESC:
                begin
                    if (c == C_CSI_OPEN)
                    begin
                        act = ACT_CLEAR;
                    end
                    else if (is_str)
                    begin
                        act = ACT_NONE;
                    end
                    else if (is_inter)
                    begin
                        act = ACT_INTER;
                    end
                    else
                    begin
                        act = ACT_ESC_DISP;
                    end
                end
                ST_ESC_INT:
                begin
                    act = is_inter ? ACT_INTER : ACT_ESC_DISP;
                end
                ST_CSI_ENTRY, ST_CSI_PARAM:
                begin
                    if ((eff_state == ST_CSI_ENTRY) && is_priv)
                    begin
                        act = ACT_PRIVATE;
                    end
                    else if (is_digit)
                    begin
                        act = ACT_DIGIT;
                    end
                    else if (is_sep)
                    begin
                        act = ACT_SEP;
                    end
                    else if (is_inter)
                    begin
                        act = ACT_INTER;
                    end
                    else if (is_final)
                    begin
                        act = ACT_CSI_DISP;
                    end
                    else
                    begin
                        act = ACT_NONE;
                    end
                end
                ST_CSI_INT:
                begin
                    if (is_inter)
                    begin
                        act = ACT_INTER;
                    end
                    else if (is_final)
                    begin
                        act = ACT_CSI_DISP;
                    end
                    else
                    begin
                        act = ACT_NONE;
                    end
                end
                default:
                begin
                    act = ACT_NONE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Collector: one RAM write at most per byte
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]      base_total, tot_m1;
    logic                  base_digits, base_sep;
    logic [MAX_PARAMS-1:0] base_mask;
    logic [5:0]            base_inter;
    logic [7:0]            base_priv;
    logic [17:0]           acc_base, acc;
    logic [13:0]           acc_sat;
    logic                  col_we;
    logic [IDX_W-1:0]      col_waddr;
    logic [14:0]           col_wdata;

    // A string's ESC clears the collection before the byte is handled.
    assign base_total  = pre_clear ? '0 : total_reg;
    assign base_digits = pre_clear ? 1'b0 : digits_reg;
    assign base_sep    = pre_clear ? 1'b0 : sep_reg;
    assign base_mask   = pre_clear ? '0 : mask_reg;
    assign base_inter  = pre_clear ? '0 : inter_reg;
    assign base_priv   = pre_clear ? '0 : priv_reg;
    assign tot_m1      = base_total - CNT_W'(1);

    // v * 10 + d, starting from zero on a new parameter
    assign acc_base = base_digits ? {4'd0, cur_reg} : 18'd0;
    assign acc      = (acc_base << 3) + (acc_base << 1) + {14'd0, c[3:0]};
    assign acc_sat  = (acc > {4'd0, PVAL_MAX}) ? PVAL_MAX : acc[13:0];

    always_comb
    begin
        total_next  = base_total;
        digits_next = base_digits;
        sep_next    = base_sep;
        mask_next   = base_mask;
        inter_next  = base_inter;
        priv_next   = base_priv;
        cur_next    = cur_reg;
        col_we      = 1'b0;
        col_waddr   = base_total[IDX_W-1:0];
        col_wdata   = PVAL_EMPTY;
        case (act)
            ACT_CLEAR:
            begin
                total_next  = '0;
                digits_next = 1'b0;
                sep_next    = 1'b0;
                mask_next   = '0;
                inter_next  = '0;
                priv_next   = '0;
            end
            ACT_INTER:
            begin
                inter_next = c[5:0];
            end
            ACT_PRIVATE:
            begin
                priv_next = c;
            end
            ACT_DIGIT:
            begin
                if (base_digits)
                begin
                    // Extend the open parameter.
                    col_we    = 1'b1;
                    col_waddr = tot_m1[IDX_W-1:0];
                    col_wdata = {1'b0, acc_sat};
                    cur_next  = acc_sat;
                end
                else if (base_total < MAX_CNT)
                begin
                    // Open a new parameter; drop digits once the store is full.
                    col_we      = 1'b1;
                    col_wdata   = {1'b0, acc_sat};
                    cur_next    = acc_sat;
                    total_next  = base_total + CNT_W'(1);
                    digits_next = 1'b1;
                    sep_next    = 1'b0;
                end
            end
            ACT_SEP:
            begin
                if (!base_digits && (base_total < MAX_CNT))
                begin
                    col_we     = 1'b1;
                    total_next = base_total + CNT_W'(1);
                end
                digits_next = 1'b0;
                sep_next    = 1'b1;
                if ((c == C_COLON) && (total_next < MAX_CNT))
                begin
                    mask_next[total_next[IDX_W-1:0]] = 1'b1;
                end
            end
            ACT_CSI_DISP:
            begin
                // A trailing separator leaves one empty parameter behind it.
                if (base_sep && (base_total < MAX_CNT))
                begin
                    col_we     = 1'b1;
                    total_next = base_total + CNT_W'(1);
                end
                digits_next = 1'b0;
                sep_next    = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Direct events: everything but a CSI dispatch with parameters
    // ------------------------------------------------------------------
    logic       dir_valid;
    logic [1:0] dir_kind;
    logic [7:0] dir_priv;
    logic [5:0] dir_inter;
    logic [14:0] dir_value;
    logic       start_run;

    always_comb
    begin
        dir_valid = 1'b0;
        dir_kind  = EV_PRINT;
        dir_priv  = '0;
        dir_inter = '0;
        dir_value = '0;
        case (act)
            ACT_PRINT:
            begin
                dir_valid = 1'b1;
                dir_kind  = EV_PRINT;
            end
            ACT_EXEC:
            begin
                dir_valid = 1'b1;
                dir_kind  = EV_EXEC;
            end
            ACT_ESC_DISP:
            begin
                dir_valid = 1'b1;
                dir_kind  = EV_ESC;
                dir_inter = base_inter;
            end
            ACT_CSI_DISP:
            begin
                dir_valid = (total_next == '0);
                dir_kind  = EV_CSI;
                dir_priv  = base_priv;
                dir_inter = base_inter;
                dir_value = PVAL_EMPTY;
            end
            default:
            begin
            end
        endcase
    end

    assign start_run = accept && (act == ACT_CSI_DISP) && (total_next != '0);

    // ------------------------------------------------------------------
    // Parameter RAM and readout
    // ------------------------------------------------------------------
    logic        load_ram, rd_issue, dir_load;
    logic [14:0] ram_rdata;

    assign load_ram = rd_pend_reg && (!out_valid_reg || results.ready);
    assign rd_issue = run_busy_reg && (rd_idx_reg < total_reg) && (!rd_pend_reg || load_ram);
    assign dir_load = accept && dir_valid;

    aesp_param_ram #(
        .DEPTH (MAX_PARAMS),
        .AW    (IDX_W),
        .DW    (15)
    ) u_param_ram (
        .clk   (clk),
        .we    (accept && col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .re    (rd_issue),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign stream.ready = !run_busy_reg && (!out_valid_reg || results.ready);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg     <= ST_GROUND;
            total_reg     <= '0;
            digits_reg    <= 1'b0;
            sep_reg       <= 1'b0;
            mask_reg      <= '0;
            inter_reg     <= '0;
            priv_reg      <= '0;
            run_busy_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                parse_reg  <= parse_next;
                total_reg  <= total_next;
                digits_reg <= digits_next;
                sep_reg    <= sep_next;
                mask_reg   <= mask_next;
                inter_reg  <= inter_next;
                priv_reg   <= priv_next;
            end

            if (start_run)
            begin
                run_busy_reg <= 1'b1;
                rd_idx_reg   <= '0;
            end
            else
            begin
                if (rd_issue)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
                if (load_ram && rd_plast_reg)
                begin
                    run_busy_reg <= 1'b0;
                end
            end

            if (rd_issue)
            begin
                rd_pend_reg <= 1'b1;
            end
            else if (load_ram)
            begin
                rd_pend_reg <= 1'b0;
            end

            if (dir_load || load_ram)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg <= cur_next;
        end
        if (start_run)
        begin
            final_reg <= c;
        end
        if (rd_issue)
        begin
            rd_pidx_reg  <= rd_idx_reg[IDX_W-1:0];
            rd_plast_reg <= ((rd_idx_reg + CNT_W'(1)) == total_reg);
        end
        if (dir_load)
        begin
            out_kind_reg  <= dir_kind;
            out_code_reg  <= c;
            out_priv_reg  <= dir_priv;
            out_inter_reg <= dir_inter;
            out_count_reg <= '0;
            out_index_reg <= '0;
            out_value_reg <= dir_value;
            out_sub_reg   <= 1'b0;
            out_last_reg  <= 1'b1;
        end
        else if (load_ram)
        begin
            out_kind_reg  <= EV_CSI;
            out_code_reg  <= final_reg;
            out_priv_reg  <= priv_reg;
            out_inter_reg <= inter_reg;
            out_count_reg <= 6'(total_reg);
            out_index_reg <= 5'(rd_pidx_reg);
            out_value_reg <= ram_rdata;
            out_sub_reg   <= mask_reg[rd_pidx_reg];
            out_last_reg  <= rd_plast_reg;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.event_kind        = out_kind_reg;
    assign results.code_byte         = out_code_reg;
    assign results.private_marker    = out_priv_reg;
    assign results.intermediate_byte = out_inter_reg;
    assign results.param_count       = out_count_reg;
    assign results.param_index       = out_index_reg;
    assign results.param_value       = $signed(out_value_reg);
    assign results.param_is_sub      = out_sub_reg;
    assign results.last_of_run       = out_last_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `AESP_ASSERT_IMP(a_run_in_ground, clk, rst_n, run_busy_reg, parse_reg == ST_GROUND)
    `AESP_ASSERT_IMP(a_pend_in_run, clk, rst_n, rd_pend_reg, run_busy_reg)
    `AESP_ASSERT_NEXT(a_last_ends_run, clk, rst_n, load_ram && rd_plast_reg, !run_busy_reg)
    `AESP_ASSERT_IMP(a_digits_need_entry, clk, rst_n, digits_reg, total_reg != '0)
    `AESP_ASSERT_IMP(a_mid_run_busy, clk, rst_n,
                     results.valid && (results.event_kind == EV_CSI) && !results.last_of_run,
                     run_busy_reg)

endmodule

`default_nettype wire

// ----- hw/rtl/aesp_param_ram.sv -----
`default_nettype none

module aesp_param_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 15
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // Hold read data until the next read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sim/aesp_event_checker.sv -----
module aesp_event_checker
    import aesp_pkg::*;
#(
    parameter int MAX_PARAMS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    aesp_byte_if      stream,
    aesp_result_if    results,
    output int        fail_count,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  code;
        logic [7:0]  marker;
        logic [5:0]  inter;
        logic [5:0]  count;
        logic [4:0]  index;
        logic [14:0] value;
        logic        sub;
        logic        last;
    } parser_event_t;

    // Shadow parser state
    parse_state_t  pstate;
    logic [14:0]   pvals [MAX_PARAMS];
    int            pcount;
    logic          in_digits;
    logic          after_sep;
    logic [31:0]   sub_bits;
    logic [7:0]    last_inter;
    logic [7:0]    marker;

    parser_event_t awaited_events[$];
    int            mismatches;

    function automatic void queue_event(logic [1:0] kind, logic [7:0] code, logic [7:0] mark,
                                        logic [7:0] inter, int count, int index,
                                        logic [14:0] value, logic sub, logic last);
        parser_event_t e;
        e.kind   = kind;
        e.code   = code;
        e.marker = mark;
        e.inter  = inter[5:0];
        e.count  = count[5:0];
        e.index  = index[4:0];
        e.value  = value;
        e.sub    = sub;
        e.last   = last;
        awaited_events.push_back(e);
    endfunction

    function automatic void clear_params();
        pcount     = 0;
        in_digits  = 1'b0;
        after_sep  = 1'b0;
        sub_bits   = '0;
        last_inter = '0;
        marker     = '0;
        foreach (pvals[i])
            pvals[i] = '0;
    endfunction

    // Close the parameter list and emit one event per parameter, or a single event when there are none.
    function automatic void dispatch_csi(logic [7:0] fin);
        int i;
        if (after_sep && pcount < MAX_PARAMS)
        begin
            pvals[pcount] = PVAL_EMPTY;
            pcount++;
        end
        after_sep = 1'b0;
        in_digits = 1'b0;
        pstate    = ST_GROUND;
        if (pcount == 0)
            queue_event(EV_CSI, fin, marker, last_inter, 0, 0, PVAL_EMPTY, 1'b0, 1'b1);
        for (i = 0; i < pcount; i++)
            queue_event(EV_CSI, fin, marker, last_inter, pcount, i, pvals[i], sub_bits[i],
                        i == pcount - 1);
    endfunction

    function automatic void parse_byte(logic [7:0] c);
        int v;
        if (pstate == ST_STRING)
        begin
            if (c == C_ESC)
                pstate = ST_STRING_ESC;
            else if (c == C_BEL || c == C_CAN || c == C_SUB)
                pstate = ST_GROUND;
            return;
        end
        if (pstate == ST_STRING_ESC)
        begin
            if (c == C_BSLASH)
            begin
                pstate = ST_GROUND;
                return;
            end
            clear_params();
            pstate = ST_ESC;
        end
        if (c < C_C0_END)
        begin
            if (c == C_ESC)
            begin
                clear_params();
                pstate = ST_ESC;
            end
            else if (c == C_CAN || c == C_SUB)
                pstate = ST_GROUND;
            else
                queue_event(EV_EXEC, c, 8'h00, 8'h00, 0, 0, '0, 1'b0, 1'b1);
            return;
        end
        case (pstate)
            ST_GROUND:
                queue_event(EV_PRINT, c, 8'h00, 8'h00, 0, 0, '0, 1'b0, 1'b1);
            ST_ESC, ST_ESC_INT:
            begin
                if (pstate == ST_ESC && c == C_CSI_OPEN)
                begin
                    clear_params();
                    pstate = ST_CSI_ENTRY;
                end
                else if (pstate == ST_ESC && (c == C_OSC || c == C_DCS || c == C_SOS ||
                                              c == C_PM || c == C_APC))
                    pstate = ST_STRING;
                else if (c <= C_INTER_HI)
                begin
                    last_inter = c;
                    pstate     = ST_ESC_INT;
                end
                else
                begin
                    pstate = ST_GROUND;
                    queue_event(EV_ESC, c, 8'h00, last_inter, 0, 0, '0, 1'b0, 1'b1);
                end
            end
            ST_CSI_ENTRY, ST_CSI_PARAM:
            begin
                if (pstate == ST_CSI_ENTRY && c >= C_PRIV_LO && c <= C_PRIV_HI)
                begin
                    marker = c;
                    pstate = ST_CSI_PARAM;
                end
                else if (c >= C_DIGIT_0 && c <= C_DIGIT_9)
                begin
                    pstate = ST_CSI_PARAM;
                    // open a fresh parameter unless one is already taking digits
                    if (!in_digits && pcount < MAX_PARAMS)
                    begin
                        pvals[pcount] = '0;
                        pcount++;
                        in_digits = 1'b1;
                        after_sep = 1'b0;
                    end
                    if (in_digits)
                    begin
                        v = (pvals[pcount - 1] == PVAL_EMPTY) ? 0 : int'(pvals[pcount - 1]);
                        v = v * 10 + int'(c - C_DIGIT_0);
                        pvals[pcount - 1] = (v > int'(PVAL_MAX)) ? 15'(PVAL_MAX) : 15'(v);
                    end
                end
                else if (c == C_SEMI || c == C_COLON)
                begin
                    pstate = ST_CSI_PARAM;
                    if (!in_digits && pcount < MAX_PARAMS)
                    begin
                        pvals[pcount] = PVAL_EMPTY;
                        pcount++;
                    end
                    in_digits = 1'b0;
                    after_sep = 1'b1;
                    if (c == C_COLON && pcount < MAX_PARAMS)
                        sub_bits[pcount] = 1'b1;
                end
                else if (c <= C_INTER_HI)
                begin
                    last_inter = c;
                    pstate     = ST_CSI_INT;
                end
                else if (c >= C_FINAL_LO && c <= C_FINAL_HI)
                    dispatch_csi(c);
                else
                    pstate = ST_CSI_IGNORE;
            end
            ST_CSI_INT:
            begin
                if (c <= C_INTER_HI)
                    last_inter = c;
                else if (c >= C_FINAL_LO && c <= C_FINAL_HI)
                    dispatch_csi(c);
                else
                    pstate = ST_CSI_IGNORE;
            end
            ST_CSI_IGNORE:
            begin
                if (c >= C_FINAL_LO && c <= C_FINAL_HI)
                    pstate = ST_GROUND;
            end
            default:
                pstate = ST_GROUND;
        endcase
    endfunction

    function automatic string describe(parser_event_t e);
        return $sformatf("kind=%0d code=%02h marker=%02h inter=%02h count=%0d index=%0d %s",
                         e.kind, e.code, e.marker, e.inter, e.count, e.index,
                         $sformatf("value=%0d sub=%0b last=%0b",
                                   $signed(e.value), e.sub, e.last));
    endfunction

    initial
    begin
        clear_params();
        pstate = ST_GROUND;
    end

    // Check the outgoing word before predicting from the incoming one: a result
    // never leaves in the same cycle as the byte that causes it.
    always @(posedge clk)
    begin
        parser_event_t seen;
        parser_event_t want;
        if (rst_n)
        begin
            if (results.valid && results.ready)
            begin
                seen = {results.event_kind, results.code_byte, results.private_marker,
                        results.intermediate_byte, results.param_count, results.param_index,
                        results.param_value, results.param_is_sub, results.last_of_run};
                if (awaited_events.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t unexpected result: %s", $realtime, describe(seen));
                end
                else
                begin
                    want = awaited_events.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t result mismatch\n  expected %s\n  actual   %s",
                                     $realtime, describe(want), describe(seen));
                    end
                end
            end
            if (stream.valid && stream.ready)
                parse_byte(stream.data_byte);
        end
        fail_count  <= mismatches;
        outstanding <= awaited_events.size();
    end

endmodule

// ----- sim/tb_ansi_escape_sequence_parser.sv -----
module tb_ansi_escape_sequence_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import aesp_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    // a 32-parameter dispatch holds the input while its parameters are read out
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_BYTES   = 72;

    logic        clk = 1'b0;
    logic        rst_n;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          fail_count;
    int          outstanding;
    int          cycle_count;
    logic [7:0]  stream_bytes[$];

    aesp_byte_if   stream_if ();
    aesp_result_if result_if ();

    ansi_escape_sequence_parser #(
        .MAX_PARAMS (32)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream_if),
        .results (result_if)
    );

    // Watches both channels, predicts every result and counts mismatches.
    aesp_event_checker #(
        .MAX_PARAMS (32)
    ) event_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream      (stream_if),
        .results     (result_if),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    // Abandon the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_ansi_escape_sequence_parser: FAIL");
            $finish;
        end
    end

    // Receiver: drop ready on a random share of cycles; hold it low in reset.
    always @(posedge clk)
        result_if.ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);

    // Offer one word and hold it until it is taken. Valid is left high after
    // the handshake so back-to-back words never lower and raise it in one step.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            stream_if.valid <= 1'b0;
            @(posedge clk);
        end
        stream_if.valid     <= 1'b1;
        stream_if.data_byte <= b;
        do
            @(posedge clk);
        while (!stream_if.ready);
    endtask

    task automatic send_plan();
        foreach (stream_bytes[i])
            send_byte(stream_bytes[i]);
        stream_bytes.delete();
    endtask

    // Stop offering words until every predicted result has come out.
    task automatic hold_until_drained();
        stream_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        int         phase;
        int         pick;
        int         n;
        int         k;
        int         ndig;
        bit         long_run;
        logic [7:0] b;

        rst_n               = 1'b0;
        stream_if.valid     = 1'b0;
        stream_if.data_byte = 8'h00;
        result_if.ready     = 1'b0;
        tx_idle_pct         = 31;
        rx_idle_pct         = 84;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: field extremes, every event kind, saturation,
        // empty and colon parameters, a bare CSI, a swallowed string, a cancel.
        stream_bytes = '{
            8'h41, 8'hFF, 8'h00,
            C_ESC, 8'h28, 8'h42,
            C_ESC, C_CSI_OPEN, C_PRIV_HI,
            C_DIGIT_9, C_DIGIT_9, C_DIGIT_9, C_DIGIT_9, C_DIGIT_9,
            C_SEMI, C_COLON, C_FINAL_HI,
            C_ESC, C_CSI_OPEN, C_FINAL_LO,
            C_ESC, C_OSC, 8'h7F, C_BEL,
            C_ESC, C_CSI_OPEN, 8'h31, C_CAN
        };
        send_plan();
        hold_until_drained();

        // Random phases: slow sender with a stalling receiver, then the
        // reverse, then full rate on both sides.
        for (phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 84 : 0;
            rx_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 31 : 0;
            while (stream_bytes.size() < PHASE_BYTES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                begin
                    // run of printable and high bytes
                    n = $urandom_range(1, 4);
                    repeat (n) stream_bytes.push_back(8'($urandom_range(8'h20, 8'hFF)));
                end
                else if (pick < 35)
                    stream_bytes.push_back(8'($urandom_range(0, 8'h1F)));
                else if (pick < 50)
                begin
                    // ESC dispatch, with up to two intermediates
                    stream_bytes.push_back(C_ESC);
                    repeat ($urandom_range(0, 2))
                        stream_bytes.push_back(8'($urandom_range(8'h20, C_INTER_HI)));
                    stream_bytes.push_back(8'($urandom_range(8'h30, 8'hFF)));
                end
                else if (pick < 80)
                begin
                    // CSI: mostly well formed, now and then overfull or broken
                    stream_bytes.push_back(C_ESC);
                    stream_bytes.push_back(C_CSI_OPEN);
                    if ($urandom_range(0, 9) < 3)
                        stream_bytes.push_back(8'($urandom_range(C_PRIV_LO, C_PRIV_HI)));
                    long_run = ($urandom_range(0, 19) == 0);
                    n = long_run ? $urandom_range(31, 36) : $urandom_range(0, 4);
                    for (k = 0; k < n; k++)
                    begin
                        if (k > 0)
                            stream_bytes.push_back(($urandom_range(0, 3) == 0) ? C_COLON
                                                                                : C_SEMI);
                        ndig = long_run ? $urandom_range(0, 1) : $urandom_range(0, 5);
                        if (ndig == 5 && $urandom_range(0, 1) == 1)
                            repeat (5) stream_bytes.push_back(C_DIGIT_9);
                        else
                            repeat (ndig)
                                stream_bytes.push_back(8'($urandom_range(C_DIGIT_0,
                                                                          C_DIGIT_9)));
                    end
                    // trailing separator leaves an empty last parameter
                    if ($urandom_range(0, 7) == 0)
                        stream_bytes.push_back(C_SEMI);
                    if ($urandom_range(0, 5) == 0)
                        repeat ($urandom_range(1, 2))
                            stream_bytes.push_back(8'($urandom_range(8'h20, C_INTER_HI)));
                    case ($urandom_range(0, 15))
                        0: stream_bytes.push_back(8'($urandom_range(0, 8'h17)));
                        1: stream_bytes.push_back(8'($urandom_range(8'h7F, 8'hFF)));
                        2: stream_bytes.push_back(C_PRIV_LO);
                        3: stream_bytes.push_back(($urandom_range(0, 1) == 1) ? C_CAN : C_SUB);
                        default: ;
                    endcase
                    stream_bytes.push_back(8'($urandom_range(C_FINAL_LO, C_FINAL_HI)));
                end
                else if (pick < 90)
                begin
                    // control string with random payload and every way out
                    stream_bytes.push_back(C_ESC);
                    case ($urandom_range(0, 4))
                        0:       stream_bytes.push_back(C_OSC);
                        1:       stream_bytes.push_back(C_DCS);
                        2:       stream_bytes.push_back(C_SOS);
                        3:       stream_bytes.push_back(C_PM);
                        default: stream_bytes.push_back(C_APC);
                    endcase
                    repeat ($urandom_range(0, 6))
                    begin
                        b = 8'($urandom_range(0, 8'hFF));
                        if (b == C_ESC || b == C_BEL || b == C_CAN || b == C_SUB)
                            b = 8'h41;
                        stream_bytes.push_back(b);
                    end
                    case ($urandom_range(0, 4))
                        0: stream_bytes.push_back(C_BEL);
                        1: stream_bytes.push_back(C_CAN);
                        2: stream_bytes.push_back(C_SUB);
                        3:
                        begin
                            stream_bytes.push_back(C_ESC);
                            stream_bytes.push_back(C_BSLASH);
                        end
                        default:
                        begin
                            // the byte after ESC starts a fresh escape
                            stream_bytes.push_back(C_ESC);
                            stream_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
                        end
                    endcase
                end
                else
                    repeat ($urandom_range(1, 3))
                        stream_bytes.push_back(8'($urandom_range(0, 8'hFF)));
            end
            send_plan();
            hold_until_drained();
        end

        // Let any late or spurious word surface before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb_ansi_escape_sequence_parser: PASS");
        else
            $display("tb_ansi_escape_sequence_parser: FAIL");
        $finish;
    end

endmodule

// ----- ansi_escape_sequence_parser.f -----
+incdir+hw/rtl
hw/rtl/aesp_pkg.sv
hw/rtl/aesp_byte_if.sv
hw/rtl/aesp_result_if.sv
hw/rtl/aesp_param_ram.sv
hw/rtl/ansi_escape_sequence_parser.sv
sim/aesp_event_checker.sv
sim/tb_ansi_escape_sequence_parser.sv
